// ===== hw/rtl/perlin_gradient_noise_2d_defines.svh =====
// Assertion macros for the 2D gradient noise block.
// Used by the port checker; needs clk_i and rst_ni in the scope of each use.
`ifndef PERLIN_GRADIENT_NOISE_2D_DEFINES_SVH
`define PERLIN_GRADIENT_NOISE_2D_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PGN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgn assertion failed");

// Next-cycle implication, checked outside reset.
`define PGN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgn assertion failed");

`endif

// ===== hw/rtl/pgn_pkg.sv =====
// Shared types and fixed widths of the 2D gradient noise block.
// No dependencies.
`default_nettype none
package pgn_pkg;

  localparam int OPC_W   = 2;
  localparam int IDX_W   = 8;
  localparam int PERM_W  = 8;
  localparam int GRAD_W  = 16;
  localparam int COORD_W = 24;
  localparam int NOISE_W = 16;
  localparam int DOT_W   = 18;
  localparam int LERP_W  = 19;

  // The last code is unused; an item carrying it is ignored.
  typedef enum logic [OPC_W-1:0] {
    OP_PERM = 2'd0,
    OP_GRAD = 2'd1,
    OP_EVAL = 2'd2,
    OP_RSVD = 2'd3
  } pgn_op_e;

endpackage
`default_nettype wire

// ===== hw/rtl/pgn_mem.sv =====
// Synchronous table memory with one write port and two registered read ports.
// No dependencies.
`default_nettype none
module pgn_mem #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr0_i,
  input  logic [$clog2(D)-1:0] raddr1_i,
  output logic [W-1:0]         rdata0_o,
  output logic [W-1:0]         rdata1_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pgn_fade.sv =====
// Two-stage fade curve s = r*r*(3-2r) in unsigned fixed point.
// No dependencies.
`default_nettype none
module pgn_fade #(
  parameter int F = 16
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [F-1:0] r_i,
  output logic [F+1:0] s_o
);
  logic [2*F:0]   sqr;
  logic [F:0]     sq_q;
  logic [F+1:0]   k_q;
  logic [2*F+2:0] prod;

  assign sqr  = (2*F+1)'(r_i) * (2*F+1)'(r_i) + ((2*F+1)'(1) << (F-1));
  assign prod = (2*F+3)'(sq_q) * (2*F+3)'(k_q) + ((2*F+3)'(1) << (F-1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sqr[2*F:F];
      k_q  <= ((F+2)'(3) << F) - (F+2)'({r_i, 1'b0});
      s_o  <= prod[2*F+1:F];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pgn_corner.sv =====
// Two-stage dot product of a corner gradient with the corner offset, rounded.
// Depends on pgn_pkg.
`default_nettype none
module pgn_corner #(
  parameter int F = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [F:0]               ox_i,
  input  logic signed [F:0]               oy_i,
  input  logic [2*pgn_pkg::GRAD_W-1:0]    grad_i,
  output logic signed [pgn_pkg::DOT_W-1:0] dot_o
);
  import pgn_pkg::*;

  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [F+16:0]     px_q, py_q;
  logic signed [F+17:0]     sum;

  assign gx  = $signed(grad_i[GRAD_W-1:0]);
  assign gy  = $signed(grad_i[2*GRAD_W-1:GRAD_W]);
  assign sum = (F+18)'(px_q) + (F+18)'(py_q) + ((F+18)'(1) << (F-1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= (F+17)'(ox_i) * (F+17)'(gx);
      py_q  <= (F+17)'(oy_i) * (F+17)'(gy);
      dot_o <= $signed(sum[F+17:F]);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pgn_blend.sv =====
// Two-stage linear interpolation a + round(s*(b-a)).
// No dependencies.
`default_nettype none
module pgn_blend #(
  parameter int F  = 16,
  parameter int IW = 18
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [F+1:0]         s_i,
  input  logic signed [IW-1:0] a_i,
  input  logic signed [IW-1:0] b_i,
  output logic signed [IW:0]   y_o
);
  localparam int PW = IW + F + 4;

  logic signed [IW:0]   diff;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;
  logic signed [IW-1:0] a_q;

  assign diff = (IW+1)'(b_i) - (IW+1)'(a_i);
  assign rnd  = prod_q + (PW'(1) << (F-1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(diff) * PW'($signed({1'b0, s_i}));
      a_q    <= a_i;
      y_o    <= (IW+1)'(a_q) + (IW+1)'($signed(rnd[PW-1:F]));
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/perlin_gradient_noise_2d.sv =====
// 2D gradient noise over loaded permutation and gradient tables.
// Results leave in the order of their evaluate items. Throughput: one item per cycle
// while the output is not stalled; three permutation copies and two gradient copies
// give every table lookup of an item its own read port, so no stage is shared.
// Reset clears only the pipeline valid bits; the tables are undefined until loaded.
// Uses pgn_pkg, pgn_mem, pgn_fade, pgn_corner and pgn_blend.
`default_nettype none
module perlin_gradient_noise_2d #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pgn_pkg::OPC_W-1:0]          opcode_i,
  input  logic [pgn_pkg::IDX_W-1:0]          table_index_i,
  input  logic [pgn_pkg::PERM_W-1:0]         perm_entry_i,
  input  logic signed [pgn_pkg::GRAD_W-1:0]  grad_x_i,
  input  logic signed [pgn_pkg::GRAD_W-1:0]  grad_y_i,
  input  logic [pgn_pkg::COORD_W-1:0]        coord_x_i,
  input  logic [pgn_pkg::COORD_W-1:0]        coord_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pgn_pkg::NOISE_W-1:0] noise_value_o
);
  import pgn_pkg::*;

  // The user must keep the table size a power of two (the block does not check); indices wrap by truncation.
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int F  = FRAC_BITS;

  // The whole pipeline advances together. It halts only while a finished result
  // waits at the output, and every memory read register halts with it, so a held
  // item keeps its read data.
  logic en, acc;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // Stage 0: lattice cell and first permutation lookup (P[x0], P[x1]).
  // Each table copy is written when a load item passes the stage that reads it,
  // so items before the load see the old entry and items after it the new one.
  logic [AW-1:0] x0, x1, y0;
  logic [PERM_W-1:0] pa0, pa1;
  assign x0 = AW'(coord_x_i >> F);
  assign x1 = x0 + AW'(1);
  assign y0 = AW'(coord_y_i >> F);

  pgn_mem #(.W(PERM_W), .D(TABLE_SIZE)) u_perm_a (
    .clk_i, .en_i(en),
    .we_i(acc && opcode_i == OP_PERM), .waddr_i(AW'(table_index_i)), .wdata_i(perm_entry_i),
    .raddr0_i(x0), .raddr1_i(x1), .rdata0_o(pa0), .rdata1_o(pa1)
  );

  logic v1_q, v2_q;
  logic [OPC_W-1:0] op1_q, op2_q;
  logic [AW-1:0] idx1_q, idx2_q, y0_1_q;
  logic [PERM_W-1:0] pe1_q;
  logic [GRAD_W-1:0] gx1_q, gy1_q, gx2_q, gy2_q;
  logic [F-1:0] rx1_q, ry1_q, rx2_q, ry2_q, rx3_q, ry3_q;
  logic [9:3] ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ev_q <= '0;
    end else if (en) begin
      v1_q <= acc;
      v2_q <= v1_q;
      ev_q <= {ev_q[8:3], v2_q && op2_q == OP_EVAL};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= opcode_i;
      idx1_q <= AW'(table_index_i);
      pe1_q  <= perm_entry_i;
      gx1_q  <= grad_x_i;
      gy1_q  <= grad_y_i;
      y0_1_q <= y0;
      rx1_q  <= coord_x_i[F-1:0];
      ry1_q  <= coord_y_i[F-1:0];
      op2_q  <= op1_q;
      idx2_q <= idx1_q;
      gx2_q  <= gx1_q;
      gy2_q  <= gy1_q;
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
    end
  end

  // Stage 1: hash the four corners through the permutation.
  logic [AW-1:0] hi, hj, y1;
  logic [PERM_W-1:0] pb00, pb10, pb01, pb11;
  assign hi = AW'(pa0);
  assign hj = AW'(pa1);
  assign y1 = y0_1_q + AW'(1);

  pgn_mem #(.W(PERM_W), .D(TABLE_SIZE)) u_perm_b0 (
    .clk_i, .en_i(en),
    .we_i(v1_q && op1_q == OP_PERM), .waddr_i(idx1_q), .wdata_i(pe1_q),
    .raddr0_i(hi + y0_1_q), .raddr1_i(hj + y0_1_q), .rdata0_o(pb00), .rdata1_o(pb10)
  );
  pgn_mem #(.W(PERM_W), .D(TABLE_SIZE)) u_perm_b1 (
    .clk_i, .en_i(en),
    .we_i(v1_q && op1_q == OP_PERM), .waddr_i(idx1_q), .wdata_i(pe1_q),
    .raddr0_i(hi + y1), .raddr1_i(hj + y1), .rdata0_o(pb01), .rdata1_o(pb11)
  );

  // Stage 2: fetch the four corner gradients; y sits in the upper half of a word.
  logic [2*GRAD_W-1:0] g00, g10, g01, g11;

  pgn_mem #(.W(2*GRAD_W), .D(TABLE_SIZE)) u_grad0 (
    .clk_i, .en_i(en),
    .we_i(v2_q && op2_q == OP_GRAD), .waddr_i(idx2_q), .wdata_i({gy2_q, gx2_q}),
    .raddr0_i(AW'(pb00)), .raddr1_i(AW'(pb10)), .rdata0_o(g00), .rdata1_o(g10)
  );
  pgn_mem #(.W(2*GRAD_W), .D(TABLE_SIZE)) u_grad1 (
    .clk_i, .en_i(en),
    .we_i(v2_q && op2_q == OP_GRAD), .waddr_i(idx2_q), .wdata_i({gy2_q, gx2_q}),
    .raddr0_i(AW'(pb01)), .raddr1_i(AW'(pb11)), .rdata0_o(g01), .rdata1_o(g11)
  );

  // Stages 3 and 4: corner dot products and both fade curves.
  // The far-corner offset r - 1 is the fraction with a set sign bit on top.
  logic signed [F:0] ox0, ox1, oy0, oy1;
  logic signed [DOT_W-1:0] d00, d10, d01, d11;
  logic [F+1:0] sx, sy, sy6_q, sy7_q;
  assign ox0 = $signed({1'b0, rx3_q});
  assign ox1 = $signed({1'b1, rx3_q});
  assign oy0 = $signed({1'b0, ry3_q});
  assign oy1 = $signed({1'b1, ry3_q});

  pgn_corner #(.F(F)) u_c00 (.clk_i, .en_i(en), .ox_i(ox0), .oy_i(oy0), .grad_i(g00), .dot_o(d00));
  pgn_corner #(.F(F)) u_c10 (.clk_i, .en_i(en), .ox_i(ox1), .oy_i(oy0), .grad_i(g10), .dot_o(d10));
  pgn_corner #(.F(F)) u_c01 (.clk_i, .en_i(en), .ox_i(ox0), .oy_i(oy1), .grad_i(g01), .dot_o(d01));
  pgn_corner #(.F(F)) u_c11 (.clk_i, .en_i(en), .ox_i(ox1), .oy_i(oy1), .grad_i(g11), .dot_o(d11));

  pgn_fade #(.F(F)) u_fade_x (.clk_i, .en_i(en), .r_i(rx3_q), .s_o(sx));
  pgn_fade #(.F(F)) u_fade_y (.clk_i, .en_i(en), .r_i(ry3_q), .s_o(sy));

  // The y fade is delayed through sy6_q and sy7_q while the x blends finish.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sy6_q <= sy;
      sy7_q <= sy6_q;
    end
  end

  // Stages 5 to 8: blend along x for both rows, then along y.
  logic signed [LERP_W-1:0] la, lb;
  logic signed [LERP_W:0]   n;

  pgn_blend #(.F(F), .IW(DOT_W)) u_lerp_a (
    .clk_i, .en_i(en), .s_i(sx), .a_i(d00), .b_i(d10), .y_o(la)
  );
  pgn_blend #(.F(F), .IW(DOT_W)) u_lerp_b (
    .clk_i, .en_i(en), .s_i(sx), .a_i(d01), .b_i(d11), .y_o(lb)
  );
  pgn_blend #(.F(F), .IW(LERP_W)) u_lerp_y (
    .clk_i, .en_i(en), .s_i(sy7_q), .a_i(la), .b_i(lb), .y_o(n)
  );

  // The final blend register is the output register; saturation is a mux after it.
  localparam logic signed [LERP_W:0] NMAX = (LERP_W+1)'(32767);
  localparam logic signed [LERP_W:0] NMIN = -(LERP_W+1)'(32768);

  assign out_valid_o = ev_q[9];

  always_comb begin
    if (n > NMAX) begin
      noise_value_o = NOISE_W'(NMAX);
    end else if (n < NMIN) begin
      noise_value_o = NOISE_W'(NMIN);
    end else begin
      noise_value_o = NOISE_W'(n);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pgn_checker.sv =====
// Port-level checks for the 2D gradient noise block, bound to its top level.
// Depends on pgn_pkg and perlin_gradient_noise_2d_defines.svh.
`default_nettype none
`include "perlin_gradient_noise_2d_defines.svh"
module pgn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [pgn_pkg::NOISE_W-1:0] noise_value_o
);
  // A stalled result stays offered and unchanged.
  `PGN_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(noise_value_o))
  // The input is held back only while a result is blocked at the output.
  `PGN_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  // Taking the result frees the input in the same cycle.
  `PGN_ASSERT_NOW(a_stall_free, out_valid_o && !out_stall_i, !in_stall_o)
endmodule

bind perlin_gradient_noise_2d pgn_checker u_pgn_checker (.*);
`default_nettype wire
